### hdl/wde_pkg.sv
// shared constants and types for the word dictionary encoder
package wde_pkg;
    localparam int DictEntries = 4096;
    localparam int WordBytes   = 32;
    localparam int IdxW        = $clog2(DictEntries);
    localparam int CntW        = $clog2(DictEntries + 1);
    localparam int PosW        = $clog2(WordBytes);
    localparam int LenW        = $clog2(WordBytes + 1);
    localparam int MemAw       = IdxW + PosW;
    localparam int TokW        = 13;

    localparam logic [1:0] StOk    = 2'd0;
    localparam logic [1:0] StTrunc = 2'd1;
    localparam logic [1:0] StFull  = 2'd2;

    typedef struct packed {
        logic [TokW-1:0] token;
        logic [1:0]      status;
        logic            new_word;
        logic            last_of_run;
    } result_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] text_byte;
    } item_t;

    // compare cell control, passed down the row each cycle
    typedef struct packed {
        logic          valid;
        logic          last;
        logic [7:0]    stored;
        logic [PosW-1:0] pos;
    } cmp_t;

    function automatic logic is_word_byte(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
               (b >= 8'h61 && b <= 8'h7A);
    endfunction
endpackage

### hdl/wde_if.sv
// valid/ready request channel interfaces
interface wde_in_if;
    import wde_pkg::*;
    logic  valid;
    logic  ready;
    item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface wde_out_if;
    import wde_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hdl/wde_cell.sv
// one cell of the pending word: holds a byte and compares it with a streamed stored byte
module wde_cell
    import wde_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  logic [PosW-1:0] my_pos,
    input  logic [7:0]      load_byte,
    input  cmp_t            cmp_in,
    input  logic            eq_in,
    output cmp_t            cmp_out,
    output logic            eq_out,
    output logic [7:0]      held_byte
);
    logic [7:0] byte_reg;
    cmp_t       cmp_reg;
    logic       eq_reg;
    logic       hit;

    assign hit = cmp_in.valid && (cmp_in.pos == my_pos);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= load_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_reg <= '0;
            eq_reg  <= 1'b0;
        end
        else
        begin
            cmp_reg <= cmp_in;
            eq_reg  <= eq_in && (!hit || (cmp_in.stored == byte_reg));
        end
    end

    assign cmp_out   = cmp_reg;
    assign eq_out    = eq_reg;
    assign held_byte = byte_reg;
endmodule

### hdl/word_dictionary_encoder_top.sv
// top level of the word dictionary encoder
//
//  channel   dir   payload                              handshake
//  in_ch     in    mode, text_byte                      valid/ready
//  out_ch    out   token, status, new_word, last_of_run valid/ready
//
// word bytes are taken while idle; a word end searches entries in order,
// streaming each entry's bytes one per cycle through a row of 32 compare
// cells, then stores a new entry byte by byte through the single-port
// entry memory if no entry matched and the dictionary is not full.
// reset clears word length, overflow flag and entry count; memories have no reset.
// results wait in an output register; the sequencer holds while it is full.
module word_dictionary_encoder_top
    import wde_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    wde_in_if.sink    in_ch,
    wde_out_if.source out_ch
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FEED  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_STORE = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_SEP   = 3'd5;

    logic [2:0]      state_reg, state_next;
    logic [LenW-1:0] len_reg, len_next;
    logic            ovf_reg, ovf_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [IdxW-1:0] ent_reg, ent_next;
    logic [LenW-1:0] pos_reg, pos_next;
    logic            sep_reg, sep_next;
    logic            last_reg, last_next;
    logic [7:0]      sepb_reg, sepb_next;
    logic            ovalid_reg, ovalid_next;
    result_t         odata_reg, odata_next;
    logic            match_reg, match_next;
    logic [IdxW-1:0] found_reg, found_next;
    logic            entry_ok_reg, entry_ok_next;

    // entry memories
    logic [7:0]      bytes_mem [DictEntries*WordBytes];
    logic [LenW-1:0] len_mem [DictEntries];
    logic [7:0]      rd_byte_reg;
    logic [LenW-1:0] rd_len_reg;
    logic            mem_we;
    logic [MemAw-1:0] mem_addr;
    logic [7:0]      mem_wdata;
    logic            feed_q1_reg, feed_last_q1_reg;
    logic [PosW-1:0] feed_pos_q1_reg;

    // cell row
    cmp_t       cmp_chain [WordBytes+1];
    logic       eq_chain [WordBytes+1];
    logic [7:0] held [WordBytes];
    logic       load_en [WordBytes];

    logic accept_in, room;
    assign room      = !ovalid_reg || out_ch.ready;
    assign accept_in = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE) && room;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = odata_reg;

    genvar g;
    generate
        for (g = 0; g < WordBytes; g++)
        begin : g_cell
            assign load_en[g] = accept_in && !in_ch.data.mode &&
                                is_word_byte(in_ch.data.text_byte) &&
                                (len_reg == LenW'(g));
            wde_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .load      (load_en[g]),
                .my_pos    (PosW'(g)),
                .load_byte (in_ch.data.text_byte),
                .cmp_in    (cmp_chain[g]),
                .eq_in     (eq_chain[g]),
                .cmp_out   (cmp_chain[g+1]),
                .eq_out    (eq_chain[g+1]),
                .held_byte (held[g])
            );
        end
    endgenerate

    // head of the row: stored bytes enter one per cycle, each flag starts
    // high when the stored length equals the pending length
    assign cmp_chain[0] = {feed_q1_reg, feed_last_q1_reg, rd_byte_reg, feed_pos_q1_reg};
    assign eq_chain[0] = feed_q1_reg ? (rd_len_reg == len_reg) : 1'b1;

    // memory port
    always_comb
    begin
        mem_we    = (state_reg == S_STORE);
        mem_addr  = {ent_reg, pos_reg[PosW-1:0]};
        mem_wdata = held[pos_reg[PosW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bytes_mem[mem_addr] <= mem_wdata;
            if (pos_reg == '0)
            begin
                len_mem[ent_reg] <= len_reg;
            end
        end
        rd_byte_reg <= bytes_mem[mem_addr];
        rd_len_reg  <= len_mem[ent_reg];
    end

    logic feed_now, feed_last_now, word_empty;
    assign word_empty    = (len_reg == '0);
    assign feed_now      = (state_reg == S_FEED);
    assign feed_last_now = feed_now && ((pos_reg + 1'b1) >= len_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feed_q1_reg      <= 1'b0;
            feed_last_q1_reg <= 1'b0;
        end
        else
        begin
            feed_q1_reg      <= feed_now;
            feed_last_q1_reg <= feed_last_now;
        end
    end

    always_ff @(posedge clk)
    begin
        feed_pos_q1_reg <= pos_reg[PosW-1:0];
    end

    // stored word matches when the last fed byte has passed all cells and
    // no earlier byte of the same entry left the row with a mismatch
    logic row_done, row_hit;
    assign row_done = cmp_chain[WordBytes].valid && cmp_chain[WordBytes].last;
    assign row_hit  = row_done && eq_chain[WordBytes] && entry_ok_reg;

    logic [1:0] wstat;
    assign wstat = ovf_reg ? StTrunc : StOk;

    always_comb
    begin
        state_next  = state_reg;
        len_next    = len_reg;
        ovf_next    = ovf_reg;
        count_next  = count_reg;
        ent_next    = ent_reg;
        pos_next    = pos_reg;
        sep_next    = sep_reg;
        last_next   = last_reg;
        sepb_next   = sepb_reg;
        match_next  = match_reg;
        found_next  = found_reg;
        entry_ok_next = entry_ok_reg;
        ovalid_next = ovalid_reg && !out_ch.ready;
        odata_next  = odata_reg;
        if (cmp_chain[WordBytes].valid && !eq_chain[WordBytes])
        begin
            entry_ok_next = 1'b0;
        end
        if (row_hit && !match_reg)
        begin
            match_next = 1'b1;
            found_next = ent_reg;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept_in)
                begin
                    sepb_next = in_ch.data.text_byte;
                    if (in_ch.data.mode)
                    begin
                        sep_next = 1'b0;
                        if (!word_empty)
                        begin
                            ent_next = '0; pos_next = '0; match_next = 1'b0;
                            state_next = (count_reg == '0) ? S_EMIT : S_FEED;
                        end
                    end
                    else if (is_word_byte(in_ch.data.text_byte))
                    begin
                        if (len_reg < LenW'(WordBytes))
                            len_next = len_reg + 1'b1;
                        else
                            ovf_next = 1'b1;
                    end
                    else
                    begin
                        sep_next = 1'b1;
                        if (!word_empty)
                        begin
                            ent_next = '0; pos_next = '0; match_next = 1'b0;
                            state_next = (count_reg == '0) ? S_EMIT : S_FEED;
                        end
                        else
                        begin
                            ovalid_next = 1'b1;
                            odata_next.token = TokW'(-$signed({1'b0, in_ch.data.text_byte}));
                            odata_next.status = StOk;
                            odata_next.new_word = 1'b0;
                            odata_next.last_of_run = 1'b1;
                        end
                    end
                end
            end
            S_FEED:
            begin
                pos_next = pos_reg + 1'b1;
                if (feed_last_now)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (row_done)
                begin
                    if (row_hit || match_reg ||
                        (CntW'(ent_reg) + 1'b1 >= count_reg))
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        ent_next = ent_reg + 1'b1;
                        pos_next = '0;
                        state_next = S_FEED;
                    end
                end
            end
            S_EMIT:
            begin
                if (room)
                begin
                    ovalid_next = 1'b1;
                    odata_next.last_of_run = !sep_reg;
                    if (match_reg)
                    begin
                        odata_next.token = TokW'(found_reg);
                        odata_next.status = wstat;
                        odata_next.new_word = 1'b0;
                        state_next = sep_reg ? S_SEP : S_IDLE;
                        len_next = '0; ovf_next = 1'b0;
                    end
                    else if (count_reg >= CntW'(DictEntries))
                    begin
                        odata_next.token = '0;
                        odata_next.status = StFull;
                        odata_next.new_word = 1'b0;
                        state_next = sep_reg ? S_SEP : S_IDLE;
                        len_next = '0; ovf_next = 1'b0;
                    end
                    else
                    begin
                        ovalid_next = ovalid_reg && !out_ch.ready;
                        ent_next = count_reg[IdxW-1:0];
                        pos_next = '0;
                        state_next = S_STORE;
                    end
                end
            end
            S_STORE:
            begin
                pos_next = pos_reg + 1'b1;
                if ((pos_reg + 1'b1) >= len_reg)
                begin
                    count_next = count_reg + 1'b1;
                    match_next = 1'b1;
                    found_next = ent_reg;
                    last_next  = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_SEP:
            begin
                if (room)
                begin
                    ovalid_next = 1'b1;
                    odata_next.token = TokW'(-$signed({1'b0, sepb_reg}));
                    odata_next.status = StOk;
                    odata_next.new_word = 1'b0;
                    odata_next.last_of_run = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // each entry's compare starts with a clean match flag
        if (state_next == S_FEED && state_reg != S_FEED)
        begin
            entry_ok_next = 1'b1;
        end
        // a freshly stored entry is flagged as new
        if (state_reg == S_EMIT && room && last_reg && match_reg)
        begin
            odata_next.new_word = 1'b1;
            last_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            len_reg      <= '0;
            ovf_reg      <= 1'b0;
            count_reg    <= '0;
            ovalid_reg   <= 1'b0;
            match_reg    <= 1'b0;
            last_reg     <= 1'b0;
            sep_reg      <= 1'b0;
            entry_ok_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            ovf_reg      <= ovf_next;
            count_reg    <= count_next;
            ovalid_reg   <= ovalid_next;
            match_reg    <= match_next;
            last_reg     <= last_next;
            sep_reg      <= sep_next;
            entry_ok_reg <= entry_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg   <= ent_next;
        pos_reg   <= pos_next;
        sepb_reg  <= sepb_next;
        odata_reg <= odata_next;
        found_reg <= found_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(DictEntries))
        else $error("entry count past dictionary size");
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LenW'(WordBytes))
        else $error("word length past buffer");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ch.ready)
        else $error("input taken while busy");
    a_store_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STORE && state_next == S_EMIT) |=>
            count_reg == $past(count_reg) + 1'b1)
        else $error("store did not grow dictionary");
`endif
endmodule
